// ----- sv/arp_cache_lookup_with_aging_assert.svh -----
`ifndef ARP_CACHE_LOOKUP_WITH_AGING_ASSERT_SVH
`define ARP_CACHE_LOOKUP_WITH_AGING_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ARPC_ASSERT_NOW(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("arp cache check failed");

// next-cycle implication, checked outside reset
`define ARPC_ASSERT_NEXT(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("arp cache check failed");

`endif

// ----- sv/arpc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package arpc_pkg;

    localparam int ENTRIES_PER_PORT_DEF = 1024;
    localparam int NUM_PORTS_DEF        = 2;

    localparam int TIMEOUT_W = 16;
    localparam int IP_W      = 32;
    localparam int MAC_W     = 48;
    localparam int TIME_W    = 32;
    localparam int OUT_IDX_W = 10;
    localparam int CFG_IDX_W = 1;

    localparam logic [TIMEOUT_W-1:0] OK_TIMEOUT_RST   = 16'd60;
    localparam logic [TIMEOUT_W-1:0] FAIL_TIMEOUT_RST = 16'd1;

    typedef enum logic [1:0] {
        ST_FREE  = 2'd0,
        ST_UNRES = 2'd1,
        ST_RES   = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OK_TIMEOUT   = 1'b0,
        REG_FAIL_TIMEOUT = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_ALLOC,
        S_RESP
    } state_t;

    typedef struct packed {
        logic              port;
        logic [IP_W-1:0]   ip_addr;
        logic              has_mac;
        logic [MAC_W-1:0]  learned_mac;
        logic [TIME_W-1:0] now_sec;
    } req_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] entry_index;
        logic                 resolved;
        logic [MAC_W-1:0]     resolved_mac;
        logic                 was_added;
        logic                 mac_learned_existing;
        logic                 send_arp_request;
        logic                 table_full;
    } rsp_t;

    typedef struct packed {
        status_t           status;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [TIME_W-1:0] last_seen;
    } entry_t;

endpackage

`default_nettype wire

// ----- sv/arp_cache_lookup_with_aging.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Per-port IPv4-to-MAC cache with aging. A request scans the used region of its port's
// table (slots below that port's fill count) through a single table memory, one entry
// read per cycle with the read pipelined against the compare/age check, ending early at
// a match unless it is an expired unresolved entry and the request brings no MAC; the
// block takes no new request meanwhile. The result sits in an output register, so a
// request may be taken while the previous result waits. The fill count per port stands
// in for clearing the table: no clearing pass runs after reset. Timeouts are written
// through the plain write port, by the user only while idle (not enforced by the block).
module arp_cache_lookup_with_aging #(
    parameter int ENTRIES_PER_PORT = arpc_pkg::ENTRIES_PER_PORT_DEF,
    parameter int NUM_PORTS        = arpc_pkg::NUM_PORTS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [arpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [arpc_pkg::TIMEOUT_W-1:0]     cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire arpc_pkg::req_t                     in_data,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output arpc_pkg::rsp_t                          out_data
);
    import arpc_pkg::*;

    localparam int SLOT_W      = $clog2(ENTRIES_PER_PORT);
    localparam int IDX_W       = $clog2(ENTRIES_PER_PORT + 1);
    localparam int TABLE_DEPTH = NUM_PORTS * ENTRIES_PER_PORT;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PORT_W      = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

    // entry table
    entry_t mem [TABLE_DEPTH];

    state_t                state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    rsp_t                  out_data_reg, out_data_next;
    logic [TIMEOUT_W-1:0]  ok_timeout_reg, fail_timeout_reg;
    logic [IDX_W-1:0]      in_use_reg [NUM_PORTS];
    logic                  in_use_we;
    logic [IDX_W-1:0]      in_use_val;

    req_t                  req_reg, req_next;
    logic [ADDR_W-1:0]     base_reg, base_next;
    logic [IDX_W-1:0]      used_reg, used_next;
    logic [IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic [SLOT_W-1:0]     ev_idx_reg, ev_idx_next;
    logic                  rd_pend_reg, rd_pend_next;
    logic                  have_free_reg, have_free_next;
    logic [SLOT_W-1:0]     free_at_reg, free_at_next;
    rsp_t                  rsp_reg, rsp_next;

    entry_t                rd_data_reg;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_raddr;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    entry_t                mem_wdata;

    logic [TIME_W-1:0]     age;
    logic                  expired;
    logic                  ip_hit;
    logic [SLOT_W-1:0]     alloc_slot;
    logic [PORT_W-1:0]     req_pidx;
    logic [PORT_W-1:0]     in_pidx;

    assign in_pidx  = PORT_W'(in_data.port);
    assign req_pidx = PORT_W'(req_reg.port);

    // age check of the entry whose read data is back
    assign age     = req_reg.now_sec - rd_data_reg.last_seen;
    assign expired = (rd_data_reg.status == ST_RES) ? (age > TIME_W'(ok_timeout_reg))
                                                    : (age > TIME_W'(fail_timeout_reg));
    assign ip_hit  = (rd_data_reg.status != ST_FREE) && (rd_data_reg.ip == req_reg.ip_addr);
    assign alloc_slot = have_free_reg ? free_at_reg : used_reg[SLOT_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        base_next      = base_reg;
        used_next      = used_reg;
        rd_idx_next    = rd_idx_reg;
        ev_idx_next    = ev_idx_reg;
        rd_pend_next   = 1'b0;
        have_free_next = have_free_reg;
        free_at_next   = free_at_reg;
        rsp_next       = rsp_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        in_use_we      = 1'b0;
        in_use_val     = used_reg + IDX_W'(1);
        mem_re         = 1'b0;
        mem_raddr      = base_reg + ADDR_W'(rd_idx_reg[SLOT_W-1:0]);
        mem_we         = 1'b0;
        mem_waddr      = base_reg + ADDR_W'(ev_idx_reg);
        mem_wdata      = rd_data_reg;
        in_stall       = (state_reg != S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next       = in_data;
                    rd_idx_next    = '0;
                    have_free_next = 1'b0;
                    free_at_next   = '0;
                    if (32'(in_data.port) >= NUM_PORTS)
                    begin
                        rsp_next            = '0;
                        rsp_next.table_full = 1'b1;
                        state_next          = S_RESP;
                    end
                    else
                    begin
                        base_next  = in_data.port ? ADDR_W'(ENTRIES_PER_PORT) : '0;
                        used_next  = in_use_reg[in_pidx];
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // issue the next read while the previous entry is checked
                if (rd_idx_reg != used_reg)
                begin
                    mem_re       = 1'b1;
                    rd_pend_next = 1'b1;
                    ev_idx_next  = rd_idx_reg[SLOT_W-1:0];
                    rd_idx_next  = rd_idx_reg + IDX_W'(1);
                end
                else if (!rd_pend_reg)
                begin
                    state_next = S_ALLOC;
                end

                if (rd_pend_reg)
                begin
                    rsp_next             = '0;
                    rsp_next.entry_index = OUT_IDX_W'(ev_idx_reg);
                    if (rd_data_reg.status == ST_FREE)
                    begin
                        if (!have_free_reg)
                        begin
                            have_free_next = 1'b1;
                            free_at_next   = ev_idx_reg;
                        end
                    end
                    else if (ip_hit && req_reg.has_mac)
                    begin
                        mem_we                        = 1'b1;
                        mem_wdata.status              = ST_RES;
                        mem_wdata.mac                 = req_reg.learned_mac;
                        mem_wdata.last_seen           = req_reg.now_sec;
                        rsp_next.resolved             = 1'b1;
                        rsp_next.resolved_mac         = req_reg.learned_mac;
                        rsp_next.mac_learned_existing = 1'b1;
                        state_next                    = S_RESP;
                    end
                    else if (ip_hit && (rd_data_reg.status == ST_RES))
                    begin
                        // a resolved hit refreshes its age and cannot expire
                        mem_we                = 1'b1;
                        mem_wdata.last_seen   = req_reg.now_sec;
                        rsp_next.resolved     = 1'b1;
                        rsp_next.resolved_mac = rd_data_reg.mac;
                        state_next            = S_RESP;
                    end
                    else if (ip_hit && !expired)
                    begin
                        rsp_next.send_arp_request = 1'b1;
                        state_next                = S_RESP;
                    end
                    else if (expired)
                    begin
                        mem_we           = 1'b1;
                        mem_wdata.status = ST_FREE;
                        if (!have_free_reg)
                        begin
                            have_free_next = 1'b1;
                            free_at_next   = ev_idx_reg;
                        end
                    end
                end
            end

            S_ALLOC:
            begin
                rsp_next   = '0;
                state_next = S_RESP;
                if (!have_free_reg && (used_reg == IDX_W'(ENTRIES_PER_PORT)))
                begin
                    rsp_next.table_full = 1'b1;
                end
                else
                begin
                    in_use_we           = !have_free_reg;
                    mem_we              = 1'b1;
                    mem_waddr           = base_reg + ADDR_W'(alloc_slot);
                    mem_wdata.ip        = req_reg.ip_addr;
                    mem_wdata.last_seen = req_reg.now_sec;
                    rsp_next.entry_index = OUT_IDX_W'(alloc_slot);
                    rsp_next.was_added   = 1'b1;
                    if (req_reg.has_mac)
                    begin
                        mem_wdata.status      = ST_RES;
                        mem_wdata.mac         = req_reg.learned_mac;
                        rsp_next.resolved     = 1'b1;
                        rsp_next.resolved_mac = req_reg.learned_mac;
                    end
                    else
                    begin
                        mem_wdata.status          = ST_UNRES;
                        mem_wdata.mac             = '0;
                        rsp_next.send_arp_request = 1'b1;
                    end
                end
            end

            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = rsp_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            out_valid_reg    <= 1'b0;
            rd_pend_reg      <= 1'b0;
            ok_timeout_reg   <= OK_TIMEOUT_RST;
            fail_timeout_reg <= FAIL_TIMEOUT_RST;
            for (int p = 0; p < NUM_PORTS; p++)
            begin
                in_use_reg[p] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rd_pend_reg   <= rd_pend_next;
            if (in_use_we)
            begin
                in_use_reg[req_pidx] <= in_use_val;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_OK_TIMEOUT:   ok_timeout_reg   <= cfg_data;
                    REG_FAIL_TIMEOUT: fail_timeout_reg <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        base_reg      <= base_next;
        used_reg      <= used_next;
        rd_idx_reg    <= rd_idx_next;
        ev_idx_reg    <= ev_idx_next;
        have_free_reg <= have_free_next;
        free_at_reg   <= free_at_next;
        rsp_reg       <= rsp_next;
        out_data_reg  <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`include "arp_cache_lookup_with_aging_assert.svh"

    `ARPC_ASSERT_NOW(a_full_stores_nothing, out_valid_reg && out_data_reg.table_full,
        !out_data_reg.was_added && !out_data_reg.resolved && !out_data_reg.send_arp_request)
    `ARPC_ASSERT_NOW(a_arp_iff_unresolved, out_valid_reg && !out_data_reg.table_full,
        out_data_reg.resolved != out_data_reg.send_arp_request)
    `ARPC_ASSERT_NOW(a_fill_bounded, 1'b1, in_use_reg[0] <= IDX_W'(ENTRIES_PER_PORT))
    `ARPC_ASSERT_NEXT(a_scan_read_lands, mem_re, rd_pend_reg && (state_reg != S_IDLE))

endmodule

`default_nettype wire
